@@ design/ptss_pkg.sv @@
// shared types and constants for the priority task slot scheduler
package ptss_pkg;

    // fixed field widths of the ports
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int FUNC_W      = 2;
    localparam int ADDR_W      = 32;
    localparam int REQ_PRIO_W  = 9;
    localparam int TSLOT_W     = 6;
    localparam int RSLOT_W     = 4;
    localparam int LIVE_W      = 5;
    localparam int RUNS_W      = 32;
    localparam int IDLE_PRIO_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_ENABLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PRIORITY = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        OP_CREATE = 2'd0,
        OP_KILL   = 2'd1,
        OP_TICK   = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RS_FREE    = 2'd0,
        RS_READY   = 2'd1,
        RS_RUNNING = 2'd2,
        RS_ZOMBIE  = 2'd3
    } run_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CSCAN,
        ST_CWAIT,
        ST_CWRITE,
        ST_KREAD,
        ST_KCHECK,
        ST_KZREAD,
        ST_KZWRITE,
        ST_TSCAN,
        ST_TWAIT,
        ST_TDECIDE,
        ST_TOLDRD,
        ST_TOLDWR,
        ST_TNEXTWR,
        ST_CURRD,
        ST_CURWAIT,
        ST_FIN
    } ptss_state_t;

endpackage

@@ design/priority_task_slot_scheduler.sv @@
// priority task slot scheduler: slot table memory, scan sequencer and result register
//
// Keeps a table of NUM_SLOTS task slots (run state, priority, run count) in one
// synchronous memory with a registered read; slot 0 is the idle task, whose
// priority is the idle_priority register. One item is worked at a time by a
// sequencer that reads, modifies and writes back the table through its single
// read and single write port. A query, a frozen tick and a create or kill that
// is refused at once (null entry, full table, slot out of range or idle slot)
// go straight to reading the current slot for the result. A kill first reads
// the target slot, also when it is not in use, and when the current task is
// killed it also sets the idle slot running. A create and an enabled tick make
// a pass over the table, one slot per cycle through the memory read port; a
// tick that switches then writes back the old and the new current slot. The
// sequencer is idle again at the edge that presents the result, so it can take
// the next item while that result is shown. A new item is taken whenever
// the sequencer is idle, even while the previous result still waits in the
// output register; the next result then waits for that one to be taken. Slot
// entries that were never written read as their reset value through a valid
// bit per slot, which reset clears; there is no clearing pass. Configuration
// is a plain write port: index 0 is sched_enable, index 1 is idle_priority.
module priority_task_slot_scheduler #(
    parameter int NUM_SLOTS = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ptss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ptss_pkg::FUNC_W-1:0]         func,
    input  logic [ptss_pkg::ADDR_W-1:0]         entry_addr,
    input  logic signed [ptss_pkg::REQ_PRIO_W-1:0] req_priority,
    input  logic signed [ptss_pkg::TSLOT_W-1:0] target_slot,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    output logic [ptss_pkg::RSLOT_W-1:0]        result_slot,
    output logic                                switched,
    output logic [ptss_pkg::LIVE_W-1:0]         live_count,
    output logic [ptss_pkg::RUNS_W-1:0]         chosen_runs
);
    import ptss_pkg::*;

    // slot index, live count and compare widths
    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int UW = $clog2(NUM_SLOTS + 1);
    localparam int CW = (PRIO_BITS > IDLE_PRIO_W) ? PRIO_BITS : IDLE_PRIO_W;
    localparam logic [PRIO_BITS-1:0] PRIO_MAX = '1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_SLOTS - 1);

    typedef struct packed {
        run_state_t           state;
        logic [PRIO_BITS-1:0] prio;
        logic [RUNS_W-1:0]    runs;
    } slot_entry_t;

    // slot table
    slot_entry_t mem [NUM_SLOTS];

    ptss_state_t st_reg, st_next;

    // architectural state and registers
    logic [IW-1:0]          current_reg;
    logic [UW-1:0]          used_reg;
    logic                   sched_en_reg;
    logic [IDLE_PRIO_W-1:0] idle_prio_reg;
    logic [NUM_SLOTS-1:0]   valid_reg;

    // memory ports
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    slot_entry_t   mem_wd;
    logic [IW-1:0] rd_addr;
    slot_entry_t   rd_data_reg;
    logic          rd_ok_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          scan_pv_reg;
    slot_entry_t   rd_entry;
    logic          rd_live;
    logic [CW-1:0] rd_prio;

    // item being worked
    op_t                  func_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [IW-1:0]        ts_reg;
    logic [IW-1:0]        cnt_reg;
    logic                 found_reg;
    logic [IW-1:0]        best_reg;
    logic [CW-1:0]        best_prio_reg;
    logic                 status_w_reg;
    logic                 created_w_reg;
    logic                 switched_w_reg;
    logic [RUNS_W-1:0]    runs_w_reg;

    // result register
    logic               out_valid_reg;
    logic               out_status_reg;
    logic [RSLOT_W-1:0] out_slot_reg;
    logic               out_switched_reg;
    logic [LIVE_W-1:0]  out_live_reg;
    logic [RUNS_W-1:0]  out_runs_reg;

    // decisions made on the accepted item
    logic                 in_fire;
    logic                 create_fail;
    logic                 kill_bad;
    logic                 tick_run;
    logic [PRIO_BITS-1:0] clip_prio;
    logic [7:0]           rp_mag;
    logic                 out_free;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign create_fail = (entry_addr == '0) || (used_reg >= UW'(NUM_SLOTS));
    // negative, beyond the table, the idle slot
    assign kill_bad    = target_slot[TSLOT_W-1]
                      || (32'(target_slot[TSLOT_W-2:0]) >= 32'(NUM_SLOTS))
                      || (target_slot[TSLOT_W-2:0] == '0);
    assign tick_run    = sched_en_reg && (used_reg > UW'(1));

    // requested priority: below one becomes one, saturate at the top
    assign rp_mag = req_priority[7:0];
    always_comb
    begin
        if (req_priority[REQ_PRIO_W-1] || (rp_mag == 8'd0))
            clip_prio = PRIO_BITS'(1);
        else if (CW'(rp_mag) > CW'(PRIO_MAX))
            clip_prio = PRIO_MAX;
        else
            clip_prio = PRIO_BITS'(rp_mag);
    end

    // entry read back, never-written slots show their reset value
    always_comb
    begin
        rd_entry = rd_data_reg;
        if (!rd_ok_reg)
        begin
            rd_entry.state = (rd_idx_reg == '0) ? RS_RUNNING : RS_FREE;
            rd_entry.prio  = '0;
            rd_entry.runs  = '0;
        end
    end

    assign rd_live = (rd_entry.state == RS_READY) || (rd_entry.state == RS_RUNNING);
    assign rd_prio = (rd_idx_reg == '0) ? CW'(idle_prio_reg) : CW'(rd_entry.prio);

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op_t'(func))
                        OP_CREATE: st_next = create_fail ? ST_CURRD : ST_CSCAN;
                        OP_KILL:   st_next = kill_bad ? ST_CURRD : ST_KREAD;
                        OP_TICK:   st_next = tick_run ? ST_TSCAN : ST_CURRD;
                        OP_QUERY:  st_next = ST_CURRD;
                    endcase
                end
            end
            ST_CSCAN:   if (cnt_reg == LAST_SLOT) st_next = ST_CWAIT;
            ST_CWAIT:   st_next = ST_CWRITE;
            ST_CWRITE:  st_next = ST_CURRD;
            ST_KREAD:   st_next = ST_KCHECK;
            ST_KCHECK:  st_next = (rd_live && (current_reg == ts_reg)) ? ST_KZREAD : ST_CURRD;
            ST_KZREAD:  st_next = ST_KZWRITE;
            ST_KZWRITE: st_next = ST_CURRD;
            ST_TSCAN:   if (cnt_reg == LAST_SLOT) st_next = ST_TWAIT;
            ST_TWAIT:   st_next = ST_TDECIDE;
            ST_TDECIDE: st_next = (best_reg == current_reg) ? ST_CURRD : ST_TOLDRD;
            ST_TOLDRD:  st_next = ST_TOLDWR;
            ST_TOLDWR:  st_next = ST_TNEXTWR;
            ST_TNEXTWR: st_next = ST_CURRD;
            ST_CURRD:   st_next = ST_CURWAIT;
            ST_CURWAIT: st_next = ST_FIN;
            ST_FIN:     if (out_free) st_next = ST_IDLE;
            default:    st_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        in_ready = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = current_reg;
        mem_wd   = rd_entry;
        rd_addr  = current_reg;
        unique case (st_reg)
            ST_IDLE:    in_ready = 1'b1;
            ST_CSCAN,
            ST_TSCAN:   rd_addr = cnt_reg;
            ST_CWRITE:
            begin
                mem_we = 1'b1;
                mem_wa = best_reg;
                mem_wd = '{state: RS_READY, prio: prio_reg, runs: '0};
            end
            ST_KREAD:   rd_addr = ts_reg;
            ST_KCHECK:
            begin
                mem_we       = rd_live;
                mem_wa       = ts_reg;
                mem_wd.state = RS_ZOMBIE;
            end
            ST_KZREAD:  rd_addr = '0;
            ST_KZWRITE:
            begin
                mem_we       = 1'b1;
                mem_wa       = '0;
                mem_wd.state = RS_RUNNING;
            end
            ST_TOLDWR:
            begin
                // old task steps down, winner read in the same cycle
                mem_we       = 1'b1;
                mem_wa       = current_reg;
                mem_wd.state = RS_READY;
                rd_addr      = best_reg;
            end
            ST_TNEXTWR:
            begin
                mem_we       = 1'b1;
                mem_wa       = best_reg;
                mem_wd.state = RS_RUNNING;
                mem_wd.runs  = rd_entry.runs + RUNS_W'(1);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // slot table, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            current_reg   <= '0;
            used_reg      <= UW'(1);
            sched_en_reg  <= 1'b0;
            idle_prio_reg <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            rd_idx_reg    <= '0;
            scan_pv_reg   <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            rd_ok_reg   <= valid_reg[rd_addr];
            rd_idx_reg  <= rd_addr;
            scan_pv_reg <= (st_reg == ST_CSCAN) || (st_reg == ST_TSCAN);

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SCHED_ENABLE:  sched_en_reg  <= cfg_data[0];
                    CFG_IDLE_PRIORITY: idle_prio_reg <= cfg_data;
                endcase
            end

            if (mem_we)
                valid_reg[mem_wa] <= 1'b1;

            if (st_reg == ST_CWRITE)
                used_reg <= used_reg + UW'(1);

            if ((st_reg == ST_KCHECK) && rd_live)
            begin
                used_reg <= used_reg - UW'(1);
                // killing the running task falls back to idle
                if (current_reg == ts_reg)
                    current_reg <= '0;
            end

            if (st_reg == ST_TNEXTWR)
                current_reg <= best_reg;

            if ((st_reg == ST_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item working registers and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg       <= op_t'(func);
            prio_reg       <= clip_prio;
            ts_reg         <= IW'(target_slot[TSLOT_W-2:0]);
            cnt_reg        <= (op_t'(func) == OP_CREATE) ? IW'(1) : '0;
            found_reg      <= 1'b0;
            best_reg       <= '0;
            best_prio_reg  <= '0;
            created_w_reg  <= 1'b0;
            switched_w_reg <= 1'b0;
            status_w_reg   <= ((op_t'(func) == OP_CREATE) && create_fail)
                           || ((op_t'(func) == OP_KILL) && kill_bad);
        end

        if ((st_reg == ST_CSCAN) || (st_reg == ST_TSCAN))
            cnt_reg <= cnt_reg + IW'(1);

        // one slot of the scan per cycle
        if (scan_pv_reg)
        begin
            if (func_reg == OP_CREATE)
            begin
                // first slot not live (free or zombie) from 1 upward
                if (!found_reg && !rd_live)
                begin
                    found_reg <= 1'b1;
                    best_reg  <= rd_idx_reg;
                end
            end
            else if (rd_live)
            begin
                // lowest number wins, ties go to the last slot other than current
                if (!found_reg || (rd_prio < best_prio_reg))
                begin
                    found_reg     <= 1'b1;
                    best_prio_reg <= rd_prio;
                    best_reg      <= rd_idx_reg;
                end
                else if ((rd_prio == best_prio_reg) && (rd_idx_reg != current_reg))
                begin
                    best_reg <= rd_idx_reg;
                end
            end
        end

        if (st_reg == ST_CWRITE)
            created_w_reg <= 1'b1;

        if ((st_reg == ST_KCHECK) && !rd_live)
            status_w_reg <= 1'b1;

        if (st_reg == ST_TNEXTWR)
            switched_w_reg <= 1'b1;

        if (st_reg == ST_CURWAIT)
            runs_w_reg <= rd_entry.runs;

        if ((st_reg == ST_FIN) && out_free)
        begin
            out_status_reg   <= status_w_reg;
            out_slot_reg     <= created_w_reg ? RSLOT_W'(best_reg) : RSLOT_W'(current_reg);
            out_switched_reg <= switched_w_reg;
            out_live_reg     <= LIVE_W'(used_reg);
            out_runs_reg     <= runs_w_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign result_slot = out_slot_reg;
    assign switched    = out_switched_reg;
    assign live_count  = out_live_reg;
    assign chosen_runs = out_runs_reg;

    // live count never leaves its range, idle always counted
    assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != '0) && (used_reg <= UW'(NUM_SLOTS)))
        else $error("live slot count out of range");

    // the table is only written while an item is worked
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (st_reg != ST_IDLE))
        else $error("slot table written while idle");

    // an accepted item always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (st_reg != ST_IDLE))
        else $error("accepted item did not start work");

    // a finished item lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        ((st_reg == ST_FIN) && out_free) |=> out_valid_reg)
        else $error("finished item not presented");

    // a switch is never reported together with a refusal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_switched_reg && out_status_reg))
        else $error("switch reported on refused item");

    // the winner write never hits the slot just stepped down
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_TNEXTWR) |-> (best_reg != current_reg))
        else $error("tick switched to the current slot");

endmodule
